### sv/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types, widths and codes of the graph component counter.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int VERTEX_W = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_ENTRIES_DEF  = 8192;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INDEX    = 2'd2;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] neighbor;
    logic                has_neighbor;
    logic                last;
  } gcc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  component_count;
    logic [STATUS_W-1:0] status;
  } gcc_out_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_SCAN,
    S_SCAN_CHK,
    S_POP,
    S_LIST,
    S_EDGE_INIT,
    S_EDGE,
    S_NB,
    S_VIS,
    S_DONE
  } gcc_state_t;

  typedef struct packed {
    logic load;
    logic begin_scan;
    logic root;
    logic next_root;
    logic pop;
    logic edge_init;
    logic nb_rd;
    logic vis_rd;
    logic enq;
    logic emit;
  } gcc_cmd_t;

  typedef struct packed {
    logic last_item;
    logic ok;
    logic visited;
    logic scan_last;
    logic queue_empty;
    logic edge_done;
    logic nb_skip;
    logic out_free;
  } gcc_status_t;

endpackage

### sv/gcc_ram.sv
// ----------------------------------------------------------------------------
// gcc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/gcc_dp.sv
// ----------------------------------------------------------------------------
// gcc_dp
// Datapath: adjacency load, list and neighbor stores, visited marks, walk
// queue, counters and the result register.
// ----------------------------------------------------------------------------
module gcc_dp import gcc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  input  gcc_in_t            in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output gcc_out_t           out_data,
  input  gcc_cmd_t           cmd,
  output gcc_status_t        st
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int QW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_ENTRIES);
  localparam int EW  = $clog2(MAX_ENTRIES + 1);

  logic [COUNT_W-1:0]  vcount_r;
  logic [EW-1:0]       entries_r;
  logic [EW-1:0]       cur_start_r;
  logic [VERTEX_W-1:0] last_seen_r;
  logic                any_seen_r;
  logic                err_idx_r;
  logic                err_ovf_r;
  logic [COUNT_W-1:0]  scan_idx_r;
  logic [QW-1:0]       head_r;
  logic [QW-1:0]       tail_r;
  logic [COUNT_W-1:0]  count_r;
  logic [EW-1:0]       e_r;
  logic [EW-1:0]       stop_r;
  logic [VERTEX_W-1:0] nb_r;
  logic                out_valid_r;
  gcc_out_t            out_data_r;

  logic                v_range;
  logic                nb_range;
  logic                seq_ok;
  logic                fresh;
  logic                entry_ok;
  logic                store_full;
  logic                nb_store;
  logic                idx_bad;
  logic [STATUS_W-1:0] status_code;

  logic                list_we;
  logic [VAW-1:0]      list_waddr;
  logic [2*EW-1:0]     list_wdata;
  logic [VAW-1:0]      list_raddr;
  logic [2*EW-1:0]     list_rdata;

  logic                nbr_we;
  logic [EAW-1:0]      nbr_waddr;
  logic [EAW-1:0]      nbr_raddr;
  logic [VERTEX_W-1:0] nbr_rdata;

  logic                vis_we;
  logic [VAW-1:0]      vis_waddr;
  logic                vis_wdata;
  logic [VAW-1:0]      vis_raddr;
  logic                vis_rdata;

  logic                q_we;
  logic [VAW-1:0]      q_waddr;
  logic [VAW-1:0]      q_wdata;
  logic [VAW-1:0]      q_raddr;
  logic [VAW-1:0]      q_rdata;

  // entry checks
  always_comb begin
    v_range  = (COUNT_W'(in_data.vertex) < vcount_r) &&
               (32'(in_data.vertex) < 32'(MAX_VERTICES));
    nb_range = (COUNT_W'(in_data.neighbor) < vcount_r) &&
               (32'(in_data.neighbor) < 32'(MAX_VERTICES));
    priority if (!any_seen_r) begin
      seq_ok = (in_data.vertex == '0);
      fresh  = 1'b1;
    end else if (in_data.vertex == last_seen_r) begin
      seq_ok = 1'b1;
      fresh  = 1'b0;
    end else if (COUNT_W'(in_data.vertex) == COUNT_W'(last_seen_r) + COUNT_W'(1)) begin
      seq_ok = 1'b1;
      fresh  = 1'b1;
    end else begin
      seq_ok = 1'b0;
      fresh  = 1'b0;
    end
    entry_ok   = v_range && (!in_data.has_neighbor || nb_range) && seq_ok;
    store_full = (entries_r == EW'(MAX_ENTRIES));
    nb_store   = entry_ok && in_data.has_neighbor && !store_full;
  end

  // status of the finished load
  always_comb begin
    idx_bad = err_idx_r || !any_seen_r ||
              (COUNT_W'(last_seen_r) != vcount_r - COUNT_W'(1));
    priority if (idx_bad) begin
      status_code = STATUS_INDEX;
    end else if (err_ovf_r) begin
      status_code = STATUS_OVERFLOW;
    end else begin
      status_code = STATUS_OK;
    end
  end

  // memory port steering
  always_comb begin
    list_we    = cmd.load && entry_ok && (fresh || nb_store);
    list_waddr = VAW'(in_data.vertex);
    list_wdata = {(fresh ? entries_r : cur_start_r),
                  (nb_store ? entries_r + EW'(1) : entries_r)};
    list_raddr = q_rdata;

    nbr_we    = cmd.load && nb_store;
    nbr_waddr = EAW'(entries_r);
    nbr_raddr = EAW'(e_r);

    vis_we    = 1'b0;
    vis_waddr = VAW'(in_data.vertex);
    vis_wdata = 1'b0;
    if (cmd.load && entry_ok && fresh) begin
      vis_we = 1'b1;
    end else if (cmd.root) begin
      vis_we    = 1'b1;
      vis_waddr = VAW'(scan_idx_r);
      vis_wdata = 1'b1;
    end else if (cmd.enq && !vis_rdata) begin
      vis_we    = 1'b1;
      vis_waddr = VAW'(nb_r);
      vis_wdata = 1'b1;
    end
    vis_raddr = cmd.vis_rd ? VAW'(nbr_rdata) : VAW'(scan_idx_r);

    q_we    = cmd.root || (cmd.enq && !vis_rdata);
    q_waddr = cmd.root ? '0 : VAW'(tail_r);
    q_wdata = cmd.root ? VAW'(scan_idx_r) : VAW'(nb_r);
    q_raddr = VAW'(head_r);
  end

  gcc_ram #(.WIDTH(2*EW), .DEPTH(MAX_VERTICES)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  gcc_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_ENTRIES)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (in_data.neighbor),
    .raddr (nbr_raddr),
    .rdata (nbr_rdata)
  );

  gcc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  gcc_ram #(.WIDTH(VAW), .DEPTH(MAX_VERTICES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // configuration and load state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= COUNT_W'(1);
      entries_r   <= '0;
      last_seen_r <= '0;
      any_seen_r  <= 1'b0;
      err_idx_r   <= 1'b0;
      err_ovf_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vcount_r <= cfg_data;
      end
      if (cmd.emit) begin
        entries_r   <= '0;
        last_seen_r <= '0;
        any_seen_r  <= 1'b0;
        err_idx_r   <= 1'b0;
        err_ovf_r   <= 1'b0;
      end else if (cmd.load) begin
        if (!entry_ok) begin
          err_idx_r <= 1'b1;
        end else begin
          if (fresh) begin
            last_seen_r <= in_data.vertex;
            any_seen_r  <= 1'b1;
          end
          if (in_data.has_neighbor) begin
            if (store_full) begin
              err_ovf_r <= 1'b1;
            end else begin
              entries_r <= entries_r + EW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && entry_ok && fresh) begin
      cur_start_r <= entries_r;
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      count_r    <= '0;
      head_r     <= '0;
      tail_r     <= '0;
    end else begin
      if (cmd.begin_scan) begin
        scan_idx_r <= '0;
        count_r    <= '0;
      end
      if (cmd.next_root) begin
        scan_idx_r <= scan_idx_r + COUNT_W'(1);
      end
      if (cmd.root) begin
        count_r <= count_r + COUNT_W'(1);
        head_r  <= '0;
        tail_r  <= QW'(1);
      end
      if (cmd.pop) begin
        head_r <= head_r + QW'(1);
      end
      if (cmd.enq && !vis_rdata) begin
        tail_r <= tail_r + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_init) begin
      e_r    <= list_rdata[2*EW-1:EW];
      stop_r <= list_rdata[EW-1:0];
    end else if (cmd.nb_rd) begin
      e_r <= e_r + EW'(1);
    end
    if (cmd.vis_rd) begin
      nb_r <= nbr_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.component_count <= count_r;
      out_data_r.status          <= status_code;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    st.last_item   = in_data.last;
    st.ok          = (status_code == STATUS_OK);
    st.visited     = vis_rdata;
    st.scan_last   = (scan_idx_r == vcount_r - COUNT_W'(1));
    st.queue_empty = (head_r == tail_r);
    st.edge_done   = (e_r >= stop_r);
    st.nb_skip     = !((COUNT_W'(nbr_rdata) < vcount_r) &&
                       (32'(nbr_rdata) < 32'(MAX_VERTICES)));
    st.out_free    = !out_valid_r || !out_stall;
  end

endmodule

### sv/gcc_ctrl.sv
// ----------------------------------------------------------------------------
// gcc_ctrl
// Controller: load handshake, root scan and breadth-first walk sequencing.
// ----------------------------------------------------------------------------
module gcc_ctrl import gcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  gcc_status_t st,
  output gcc_cmd_t    cmd
);

  gcc_state_t state_r;
  gcc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_LOAD);
    unique case (state_r)
      S_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && st.last_item) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.begin_scan = 1'b1;
        state_nxt      = st.ok ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (st.visited) begin
          cmd.next_root = 1'b1;
          state_nxt     = st.scan_last ? S_DONE : S_SCAN;
        end else begin
          cmd.root  = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (st.queue_empty) begin
          cmd.next_root = 1'b1;
          state_nxt     = st.scan_last ? S_DONE : S_SCAN;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_LIST;
        end
      end
      S_LIST: begin
        state_nxt = S_EDGE_INIT;
      end
      S_EDGE_INIT: begin
        cmd.edge_init = 1'b1;
        state_nxt     = S_EDGE;
      end
      S_EDGE: begin
        if (st.edge_done) begin
          state_nxt = S_POP;
        end else begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (st.nb_skip) begin
          state_nxt = S_EDGE;
        end else begin
          cmd.vis_rd = 1'b1;
          state_nxt  = S_VIS;
        end
      end
      S_VIS: begin
        cmd.enq   = 1'b1;
        state_nxt = S_EDGE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

### sv/graph_component_counter.sv
// ----------------------------------------------------------------------------
// graph_component_counter
// Loading takes one adjacency entry per cycle. After the item marked last
// the block counts connected components with breadth-first walks over
// stores that give one read per cycle and then presents one count with a
// status. A load with an error skips the walks. The load stalls from the
// transfer of the last item until the result is in the output register,
// including any wait for that register to drain. The next load may start
// while the result still waits in its output register.
// ----------------------------------------------------------------------------
module graph_component_counter import gcc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  gcc_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gcc_out_t           out_data
);

  gcc_cmd_t    cmd;
  gcc_status_t st;

  gcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  gcc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_ENTRIES  (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
